[design/bvmp_pkg.sv]
`default_nettype none

package bvmp_pkg;

	// Widths of the configuration port and the default tick counter width.
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int COUNT_BITS_DEF = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PTT_LEAD   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd7;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd200;
	localparam logic [CFG_W-1:0] PTT_LEAD_RST   = 16'd30;

	// Volume levels.
	localparam logic [2:0] LEVEL_MIN = 3'd1;
	localparam logic [2:0] LEVEL_MAX = 3'd5;
	localparam logic [2:0] LEVEL_RST = 3'd3;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_DEBOUNCE  = 3'd1,
		PH_HOLD_MUTE = 3'd2,
		PH_PTT_LEAD  = 3'd3,
		PH_PTT_TALK  = 3'd4,
		PH_WAIT_REL  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		KEY_NONE = 3'd0,
		KEY_MUTE = 3'd1,
		KEY_TALK = 3'd2,
		KEY_UP   = 3'd3,
		KEY_DOWN = 3'd4
	} key_t;

	// Sampled button levels of one tick, all active low.
	typedef struct packed {
		logic mute_n;
		logic talk_n;
		logic up_n;
		logic down_n;
	} keys_t;

	// Output pin image.
	typedef struct packed {
		logic mute;
		logic talk;
		logic pd;
		logic led;
		logic en;
		logic in1;
		logic in2;
	} pins_t;

	localparam pins_t PINS_RST = '{mute: 1'b0, talk: 1'b0, pd: 1'b0, led: 1'b1,
		en: 1'b1, in1: 1'b0, in2: 1'b0};

	// Switch pattern {enable, IN1, IN2} for a volume level.
	function automatic logic [2:0] level_pins(input logic [2:0] level);
		logic [2:0] p;
		case (level)
			3'd2:    p = 3'b000;
			3'd3:    p = 3'b010;
			3'd4:    p = 3'b001;
			3'd5:    p = 3'b011;
			default: p = 3'b100;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

[design/bvmp_core.sv]
`default_nettype none

module bvmp_core #(
	parameter int COUNT_BITS = bvmp_pkg::COUNT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire bvmp_pkg::keys_t              keys,
	input  wire logic [bvmp_pkg::CFG_W-1:0]   debounce_ticks,
	input  wire logic [bvmp_pkg::CFG_W-1:0]   long_press_ticks,
	input  wire logic [bvmp_pkg::CFG_W-1:0]   ptt_lead_ticks,
	output bvmp_pkg::pins_t                   pins,
	output logic [2:0]                        volume_level
);
	import bvmp_pkg::*;

	localparam int CmpW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam logic [COUNT_BITS-1:0] CountMax = '1;

	phase_t                phase_q, phase_d;
	key_t                  key_q, key_d, first_key;
	logic [COUNT_BITS-1:0] count_q, count_d, count_inc;
	logic                  long_q, long_d;
	logic                  muted_q, muted_d;
	logic [2:0]            level_q, level_d;
	pins_t                 pins_q, pins_d;
	logic                  held, db_hit, long_hit, lead_hit;

	// A threshold above the counter range counts as the counter maximum.
	function automatic logic at_limit(input logic [COUNT_BITS-1:0] cnt,
		input logic [CFG_W-1:0] lim);
		logic [CmpW-1:0] c;
		logic [CmpW-1:0] l;
		logic [CmpW-1:0] m;
		c = CmpW'(cnt);
		l = CmpW'(lim);
		m = CmpW'(CountMax);
		if (l > m) begin
			l = m;
		end
		return c >= l;
	endfunction

	// Level of the button being handled.
	always_comb begin
		case (key_q)
			KEY_MUTE: held = ~keys.mute_n;
			KEY_TALK: held = ~keys.talk_n;
			KEY_UP:   held = ~keys.up_n;
			KEY_DOWN: held = ~keys.down_n;
			default:  held = 1'b0;
		endcase
	end

	// Fixed-priority pick of a new press.
	always_comb begin
		if (!keys.mute_n) begin
			first_key = KEY_MUTE;
		end else if (!keys.talk_n) begin
			first_key = KEY_TALK;
		end else if (!keys.up_n) begin
			first_key = KEY_UP;
		end else if (!keys.down_n) begin
			first_key = KEY_DOWN;
		end else begin
			first_key = KEY_NONE;
		end
	end

	// Saturating tick count and the three threshold checks.
	assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;
	assign db_hit    = at_limit(count_inc, debounce_ticks);
	assign long_hit  = at_limit(count_inc, long_press_ticks);
	assign lead_hit  = at_limit(count_inc, ptt_lead_ticks);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (first_key != KEY_NONE) begin
					phase_d = PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE: begin
				if (db_hit) begin
					if (!held) begin
						phase_d = PH_IDLE;
					end else begin
						case (key_q)
							KEY_MUTE:         phase_d = PH_HOLD_MUTE;
							KEY_TALK:         phase_d = PH_PTT_LEAD;
							KEY_UP, KEY_DOWN: phase_d = PH_WAIT_REL;
							default:          phase_d = PH_IDLE;
						endcase
					end
				end
			end
			PH_HOLD_MUTE, PH_PTT_TALK, PH_WAIT_REL: begin
				if (!held) begin
					phase_d = PH_IDLE;
				end
			end
			PH_PTT_LEAD: begin
				if (lead_hit) begin
					phase_d = PH_PTT_TALK;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Counter, flags, level and pin updates for this tick.
	always_comb begin
		key_d   = key_q;
		count_d = count_q;
		long_d  = long_q;
		muted_d = muted_q;
		level_d = level_q;
		pins_d  = pins_q;
		case (phase_q)
			PH_IDLE: begin
				key_d = first_key;
				if (first_key != KEY_NONE) begin
					count_d = '0;
				end
			end
			PH_DEBOUNCE: begin
				count_d = count_inc;
				if (db_hit) begin
					count_d = '0;
					if (held && key_q == KEY_MUTE) begin
						long_d = 1'b0;
					end
					if (held && key_q == KEY_TALK) begin
						pins_d.pd = 1'b1;
					end
				end
			end
			PH_HOLD_MUTE: begin
				if (held) begin
					count_d = count_inc;
					if (long_hit) begin
						long_d = 1'b1;
					end
				end else begin
					if (long_q) begin
						muted_d     = ~muted_q;
						pins_d.mute = muted_q;
					end
					long_d = 1'b0;
				end
			end
			PH_PTT_LEAD: begin
				count_d = count_inc;
				if (lead_hit) begin
					pins_d.talk = 1'b1;
					pins_d.led  = 1'b0;
				end
			end
			PH_PTT_TALK: begin
				if (!held) begin
					pins_d.talk = 1'b0;
					pins_d.pd   = 1'b0;
					pins_d.led  = 1'b1;
				end
			end
			PH_WAIT_REL: begin
				if (!held) begin
					if (key_q == KEY_UP && level_q > LEVEL_MIN && level_q <= LEVEL_MAX) begin
						level_d = level_q - 3'd1;
						{pins_d.en, pins_d.in1, pins_d.in2} = level_pins(level_d);
					end else if (key_q == KEY_DOWN && level_q >= LEVEL_MIN &&
						level_q < LEVEL_MAX) begin
						level_d = level_q + 3'd1;
						{pins_d.en, pins_d.in1, pins_d.in2} = level_pins(level_d);
					end
				end
			end
			default: begin
			end
		endcase
		if (phase_d == PH_IDLE) begin
			key_d = KEY_NONE;
		end
	end

	// State registers, which also hold the result of the last tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			key_q   <= KEY_NONE;
			count_q <= '0;
			long_q  <= 1'b0;
			muted_q <= 1'b0;
			level_q <= LEVEL_RST;
			pins_q  <= PINS_RST;
		end else if (step) begin
			phase_q <= phase_d;
			key_q   <= key_d;
			count_q <= count_d;
			long_q  <= long_d;
			muted_q <= muted_d;
			level_q <= level_d;
			pins_q  <= pins_d;
		end
	end

	// Outputs.
	always_comb begin
		pins         = pins_q;
		volume_level = level_q;
	end

endmodule

`default_nettype wire

[design/button_volume_mute_ptt_controller.sv]
// A word accepted at the input passes through an input register and then a state
// and result register before it reaches the output.
// Throughput: one word per cycle; out_stall holds the result and stalls the input.
// Reset: arst_n clears the pipeline, returns the controller to idle with level 3,
// drives the level-one switch pattern and loads the default tick thresholds.
`default_nettype none

module button_volume_mute_ptt_controller #(
	parameter int COUNT_BITS = bvmp_pkg::COUNT_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            mute_key_n,
	input  wire logic                            talk_key_n,
	input  wire logic                            louder_key_n,
	input  wire logic                            quieter_key_n,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 mute_pin,
	output logic                                 talk_out,
	output logic                                 power_down_pin,
	output logic                                 led_pin,
	output logic                                 switch_enable,
	output logic                                 switch_sel_low,
	output logic                                 switch_sel_high,
	output logic [2:0]                           volume_level,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bvmp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bvmp_pkg::CFG_W-1:0]      cfg_data
);
	import bvmp_pkg::*;

	logic             s1_valid_q;
	keys_t            keys_s1;
	logic             out_valid_q;
	logic             advance;
	logic             step;
	logic [CFG_W-1:0] debounce_q, long_press_q, ptt_lead_q;
	pins_t            pins;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			ptt_lead_q   <= PTT_LEAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				REG_PTT_LEAD:   ptt_lead_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow: the result register moves whenever it is empty or taken.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !advance;
	assign step     = s1_valid_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				s1_valid_q <= in_valid;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// Input word register.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			keys_s1 <= '{mute_n: mute_key_n, talk_n: talk_key_n,
				up_n: louder_key_n, down_n: quieter_key_n};
		end
	end

	bvmp_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.keys            (keys_s1),
		.debounce_ticks  (debounce_q),
		.long_press_ticks(long_press_q),
		.ptt_lead_ticks  (ptt_lead_q),
		.pins            (pins),
		.volume_level    (volume_level)
	);

	// Result word.
	assign out_valid       = out_valid_q;
	assign mute_pin        = pins.mute;
	assign talk_out        = pins.talk;
	assign power_down_pin  = pins.pd;
	assign led_pin         = pins.led;
	assign switch_enable   = pins.en;
	assign switch_sel_low  = pins.in1;
	assign switch_sel_high = pins.in2;

	// Talking always happens inside the power-down window.
	assert property (@(posedge clk) disable iff (!arst_n) talk_out |-> power_down_pin)
		else $error("talk output high without power-down");

	// The LED pin is low exactly while talking.
	assert property (@(posedge clk) disable iff (!arst_n) led_pin == !talk_out)
		else $error("LED does not follow talk output");

	// The volume level never leaves its range.
	assert property (@(posedge clk) disable iff (!arst_n)
		volume_level >= LEVEL_MIN && volume_level <= LEVEL_MAX)
		else $error("volume level out of range");

	// A word that leaves the input register shows up as a result next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) step |=> out_valid)
		else $error("processed word did not reach the output");

endmodule

`default_nettype wire

[tb/button_volume_mute_ptt_controller_test.sv]
`timescale 1ns / 100ps

import bvmp_pkg::*;

// One output word: the pin image and the volume level after one tick.
typedef struct packed {
	pins_t      pins;
	logic [2:0] level;
} pin_word_t;

// Tracks the controller state tick by tick and checks the output words in order.
class tick_scoreboard;
	logic [CFG_W-1:0] debounce_lim;
	logic [CFG_W-1:0] long_lim;
	logic [CFG_W-1:0] lead_lim;
	phase_t           ph;
	key_t             key;
	logic [15:0]      ticks;
	logic             long_hit;
	logic             muted;
	logic [2:0]       level;
	pins_t            pins;
	pin_word_t        pending_pins[$];
	int               mismatches;

	function new();
		debounce_lim = DEBOUNCE_RST;
		long_lim = LONG_PRESS_RST;
		lead_lim = PTT_LEAD_RST;
		ph = PH_IDLE;
		key = KEY_NONE;
		ticks = '0;
		long_hit = 1'b0;
		muted = 1'b0;
		level = LEVEL_RST;
		pins = PINS_RST;
		mismatches = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		case (idx)
			REG_DEBOUNCE:   debounce_lim = value;
			REG_LONG_PRESS: long_lim = value;
			REG_PTT_LEAD:   lead_lim = value;
			default: ;
		endcase
	endfunction

	function int pending();
		return pending_pins.size();
	endfunction

	function bit is_held(key_t k, keys_t in);
		case (k)
			KEY_MUTE: return !in.mute_n;
			KEY_TALK: return !in.talk_n;
			KEY_UP:   return !in.up_n;
			KEY_DOWN: return !in.down_n;
			default:  return 1'b0;
		endcase
	endfunction

	// The tick counter saturates at its all-ones value.
	function void bump();
		if (ticks != '1)
			ticks = ticks + 1'b1;
	endfunction

	// Level 1 drives the enable pin; levels 2 to 5 select through IN1 and IN2.
	function void set_level(logic [2:0] lvl);
		level = lvl;
		case (lvl)
			3'd2:    {pins.en, pins.in1, pins.in2} = 3'b000;
			3'd3:    {pins.en, pins.in1, pins.in2} = 3'b010;
			3'd4:    {pins.en, pins.in1, pins.in2} = 3'b001;
			3'd5:    {pins.en, pins.in1, pins.in2} = 3'b011;
			default: {pins.en, pins.in1, pins.in2} = 3'b100;
		endcase
	endfunction

	// Advances the controller by one accepted tick and queues the word it shows.
	function void note_tick(keys_t in);
		bit held;
		held = is_held(key, in);
		case (ph)
			PH_IDLE: begin
				// A new press is taken in priority order.
				if (!in.mute_n)
					key = KEY_MUTE;
				else if (!in.talk_n)
					key = KEY_TALK;
				else if (!in.up_n)
					key = KEY_UP;
				else if (!in.down_n)
					key = KEY_DOWN;
				else
					key = KEY_NONE;
				if (key != KEY_NONE) begin
					ticks = '0;
					ph = PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE: begin
				bump();
				if (ticks >= debounce_lim) begin
					ticks = '0;
					if (!held) begin
						ph = PH_IDLE;
					end else begin
						case (key)
							KEY_MUTE: begin
								long_hit = 1'b0;
								ph = PH_HOLD_MUTE;
							end
							KEY_TALK: begin
								pins.pd = 1'b1;
								ph = PH_PTT_LEAD;
							end
							KEY_UP, KEY_DOWN: ph = PH_WAIT_REL;
							default: ph = PH_IDLE;
						endcase
					end
				end
			end
			PH_HOLD_MUTE: begin
				// Mute toggles on release, and only after a long enough hold.
				if (held) begin
					bump();
					if (ticks >= long_lim)
						long_hit = 1'b1;
				end else begin
					if (long_hit) begin
						muted = !muted;
						pins.mute = !muted;
					end
					long_hit = 1'b0;
					ph = PH_IDLE;
				end
			end
			PH_PTT_LEAD: begin
				// The lead runs to its end even if the button is already up.
				bump();
				if (ticks >= lead_lim) begin
					pins.talk = 1'b1;
					pins.led = 1'b0;
					ph = PH_PTT_TALK;
				end
			end
			PH_PTT_TALK: begin
				if (!held) begin
					pins.talk = 1'b0;
					pins.pd = 1'b0;
					pins.led = 1'b1;
					ph = PH_IDLE;
				end
			end
			PH_WAIT_REL: begin
				// Volume steps on release and saturates at both ends.
				if (!held) begin
					if (key == KEY_UP && level > LEVEL_MIN && level <= LEVEL_MAX)
						set_level(level - 3'd1);
					else if (key == KEY_DOWN && level >= LEVEL_MIN && level < LEVEL_MAX)
						set_level(level + 3'd1);
					ph = PH_IDLE;
				end
			end
			default: ph = PH_IDLE;
		endcase
		if (ph == PH_IDLE)
			key = KEY_NONE;
		pending_pins.push_back('{pins: pins, level: level});
	endfunction

	task report(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	task check_field(string name, logic [2:0] got, logic [2:0] want);
		if (got !== want)
			report($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Compares one output word with the oldest pending one, field by field.
	task check_pins(pin_word_t got);
		pin_word_t want;
		if (pending_pins.size() == 0) begin
			report("output word arrived with none pending");
			return;
		end
		want = pending_pins.pop_front();
		check_field("mute_pin", 3'(got.pins.mute), 3'(want.pins.mute));
		check_field("talk_out", 3'(got.pins.talk), 3'(want.pins.talk));
		check_field("power_down_pin", 3'(got.pins.pd), 3'(want.pins.pd));
		check_field("led_pin", 3'(got.pins.led), 3'(want.pins.led));
		check_field("switch_enable", 3'(got.pins.en), 3'(want.pins.en));
		check_field("switch_sel_low", 3'(got.pins.in1), 3'(want.pins.in1));
		check_field("switch_sel_high", 3'(got.pins.in2), 3'(want.pins.in2));
		check_field("volume_level", got.level, want.level);
	endtask
endclass

module button_volume_mute_ptt_controller_test;

	localparam int CYCLE_LIMIT = 2_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 mute_key_n = 1'b1;
	logic                 talk_key_n = 1'b1;
	logic                 louder_key_n = 1'b1;
	logic                 quieter_key_n = 1'b1;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 mute_pin;
	logic                 talk_out;
	logic                 power_down_pin;
	logic                 led_pin;
	logic                 switch_enable;
	logic                 switch_sel_low;
	logic                 switch_sel_high;
	logic [2:0]           volume_level;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
	logic [CFG_W-1:0]     cfg_data = '0;

	tick_scoreboard sb;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             ticks_sent = 0;
	int             cycle_count = 0;

	button_volume_mute_ptt_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mute_key_n(mute_key_n),
		.talk_key_n(talk_key_n),
		.louder_key_n(louder_key_n),
		.quieter_key_n(quieter_key_n),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mute_pin(mute_pin),
		.talk_out(talk_out),
		.power_down_pin(power_down_pin),
		.led_pin(led_pin),
		.switch_enable(switch_enable),
		.switch_sel_low(switch_sel_low),
		.switch_sel_high(switch_sel_high),
		.volume_level(volume_level),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random at the current rate.
	always @(posedge clk) begin
		out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
	end

	// Both handshakes are sampled at the clock edge with their pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_tick(keys_t'({mute_key_n, talk_key_n, louder_key_n, quieter_key_n}));
			if (out_valid && !out_stall)
				sb.check_pins(pin_word_t'({mute_pin, talk_out, power_down_pin, led_pin,
					switch_enable, switch_sel_low, switch_sel_high, volume_level}));
		end
	end

	// A hung handshake ends the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Sends one tick word {mute, talk, up, down}, with random idle cycles ahead of it.
	task automatic send_tick(input logic [3:0] v);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{mute_key_n, talk_key_n, louder_key_n, quieter_key_n} <= v;
		do @(posedge clk); while (in_stall);
		ticks_sent++;
	endtask

	// Stops sending until every pending word is out, then lets the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes all three thresholds back to back on the configuration channel.
	task automatic load_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
		input logic [CFG_W-1:0] lead);
		logic [CFG_W-1:0] vals[3];
		logic [CFG_IDX_W-1:0] idxs[3];
		vals = '{deb, hold, lead};
		idxs = '{REG_DEBOUNCE, REG_LONG_PRESS, REG_PTT_LEAD};
		for (int r = 0; r < 3; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[r];
			cfg_data <= vals[r];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idxs[r], vals[r]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random presses: a button held for a random time with noise on the others,
	// then released; now and then a burst of random levels.
	task automatic run_presses(input int n);
		int stop_at;
		int t;
		int hold;
		int rel;
		int i;
		int j;
		logic [3:0] v;
		stop_at = ticks_sent + n;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(9) == 0) begin
				rel = $urandom_range(1, 4);
				for (i = 0; i < rel; i++)
					send_tick(4'($urandom_range(15)));
			end else begin
				t = $urandom_range(3);
				hold = $urandom_range(1, int'(sb.debounce_lim) + int'(sb.long_lim) +
					int'(sb.lead_lim) + 6);
				// The first press tick keeps higher-priority buttons up.
				v = 4'($urandom_range(15));
				for (j = 0; j < 4; j++)
					if (j > 3 - t)
						v[j] = 1'b1;
				v[3 - t] = 1'b0;
				send_tick(v);
				for (i = 1; i < hold; i++) begin
					v = ($urandom_range(1) == 1) ? 4'b1111 : 4'($urandom_range(15));
					v[3 - t] = 1'b0;
					send_tick(v);
				end
				rel = $urandom_range(1, 4);
				for (i = 0; i < rel; i++) begin
					v = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'b1111;
					v[3 - t] = 1'b1;
					send_tick(v);
				end
			end
		end
	endtask

	initial begin
		logic [3:0] directed[$];
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks: short and long mute holds, all buttons at once, a release
		// during the talk lead, other buttons while busy, and both volume directions.
		load_thresholds(16'd0, 16'd1, 16'd2);
		directed = '{4'b1111,
			4'b0111, 4'b0111, 4'b1111,
			4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b1111,
			4'b1011, 4'b1011, 4'b1111, 4'b1111, 4'b1111,
			4'b1101, 4'b1100, 4'b0101, 4'b1111,
			4'b1110, 4'b1110, 4'b1111,
			4'b0111, 4'b0111, 4'b0111, 4'b0111, 4'b1111};
		foreach (directed[d])
			send_tick(directed[d]);

		// Three idling patterns, each with thresholds of zero, of one and at random.
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 29 : (p == 1) ? 77 : 0;
			recv_idle_pct = (p == 0) ? 77 : (p == 1) ? 29 : 0;
			for (int c = 0; c < 3; c++) begin
				drain();
				if (c == 0)
					load_thresholds(16'd0, 16'd0, 16'd0);
				else if (c == 1)
					load_thresholds(16'd1, 16'd1, 16'd1);
				else
					load_thresholds(16'($urandom_range(2, 6)), 16'($urandom_range(2, 12)),
						16'($urandom_range(2, 8)));
				run_presses(200);
			end
		end

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
